// ----- sv/wpms_pkg.sv -----
// ----------------------------------------------------------------------------
// wpms_pkg: shared types and codes of the window peak match selector
// Item and result payloads, the queue entry between front and back, register
// indexes and search mode codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpms_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_TIME    = 2'd1;
    localparam int CFG_DATA_W = 2;

    // Search mode codes
    localparam logic [1:0] MODE_ALL           = 2'd0;
    localparam logic [1:0] MODE_MIN_ERROR     = 2'd1;
    localparam logic [1:0] MODE_MAX_INTENSITY = 2'd2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        flush;
        logic [15:0] query_index;
        logic [15:0] target_mass;
        logic [31:0] expected_pos;
        logic [31:0] window_low;
        logic [31:0] window_high;
        logic [31:0] scan_index_pos;
        logic [31:0] scan_time;
        logic [15:0] peak_mz;
        logic [30:0] peak_intensity;
    } item_t;

    typedef struct packed {
        logic [15:0] found_query;
        logic [31:0] found_index_pos;
        logic [31:0] found_time;
        logic [30:0] found_intensity;
    } found_t;

    // Classified match (or flush) handed from front to back
    typedef struct packed {
        logic        flush;
        logic [15:0] query_raw;
        logic [15:0] query_quot;
        logic [31:0] index_pos;
        logic [31:0] time_pos;
        logic [30:0] intensity;
        logic [31:0] error;
    } entry_t;

endpackage

`default_nettype wire

// ----- sv/wpms_if.sv -----
// ----------------------------------------------------------------------------
// wpms_if: valid/ready channels of the window peak match selector
// One interface for candidate items, one for reported peaks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wpms_item_if;
    logic            valid;
    logic            ready;
    wpms_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wpms_found_if;
    logic             valid;
    logic             ready;
    wpms_pkg::found_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/wpms_front.sv -----
// ----------------------------------------------------------------------------
// wpms_front: match test and classification
// Tests m/z and window, computes the position error and the quotient estimate
// for the query reduction, and pushes matches and flush items to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpms_front #(
    parameter int MAX_QUERIES = 65536
) (
    wpms_item_if.sink        item,
    input  wire logic        use_time,
    input  wire logic        queue_full,
    output logic             push,
    output wpms_pkg::entry_t push_entry
);

    // Reciprocal of the query count, scaled by 2^32
    localparam longint unsigned RECIP_FULL = 64'h1_0000_0000 / MAX_QUERIES;
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];

    logic [31:0] pos;
    logic        hit;
    logic [47:0] quot_prod;

    assign item.ready = !queue_full;

    // Select position and test the window
    always_comb
    begin
        pos = use_time ? item.data.scan_time : item.data.scan_index_pos;
        hit = (item.data.peak_mz == item.data.target_mass)
              && (item.data.window_low < pos) && (pos < item.data.window_high);
    end

    // Estimate the quotient of the query index; the back corrects it
    assign quot_prod = {16'd0, item.data.query_index} * {16'd0, RECIP};

    // Build the queue entry
    always_comb
    begin
        push_entry.flush      = item.data.flush;
        push_entry.query_raw  = item.data.query_index;
        push_entry.query_quot = quot_prod[47:32];
        push_entry.index_pos  = item.data.scan_index_pos;
        push_entry.time_pos   = item.data.scan_time;
        push_entry.intensity  = item.data.peak_intensity;
        push_entry.error      = (item.data.expected_pos >= pos)
                                ? (item.data.expected_pos - pos)
                                : (pos - item.data.expected_pos);
    end

    // Drop items that neither match nor flush
    assign push = item.valid && !queue_full && (item.data.flush || hit);

endmodule

`default_nettype wire

// ----- sv/wpms_queue.sv -----
// ----------------------------------------------------------------------------
// wpms_queue: short queue between front and back
// Holds classified entries so that front and back stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpms_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire wpms_pkg::entry_t push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output wpms_pkg::entry_t      head_entry
);

    localparam int PTR_W = $clog2(wpms_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wpms_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(wpms_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(wpms_pkg::QUEUE_DEPTH - 1);

    wpms_pkg::entry_t entries_reg [wpms_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wpms_back.sv -----
// ----------------------------------------------------------------------------
// wpms_back: best-match keeper and result register
// Finishes the query reduction, applies the search mode to the held best
// match and loads reported peaks into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpms_back #(
    parameter int MAX_QUERIES = 65536
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       search_mode,
    input  wire logic             head_valid,
    input  wire wpms_pkg::entry_t head_entry,
    output logic                  pop,
    wpms_found_if.source          found
);

    localparam int MQ_W  = $clog2(MAX_QUERIES + 1);
    localparam int REM_W = (MQ_W > 16) ? MQ_W : 16;
    localparam logic [MQ_W-1:0]  MQ     = MQ_W'(MAX_QUERIES);
    localparam logic [REM_W-1:0] MQ_EXT = REM_W'(MAX_QUERIES);

    logic             have_best_reg, have_best_next;
    wpms_pkg::found_t best_reg, best_next;
    logic [31:0]      best_error_reg, best_error_next;
    logic             found_valid_reg, found_valid_next;
    wpms_pkg::found_t found_data_reg, found_data_next;

    logic [16+MQ_W-1:0] back_prod;
    logic [15:0]        rem_est;
    logic [REM_W-1:0]   rem_ext;
    logic [15:0]        query;
    wpms_pkg::found_t   cand;
    logic               emit_now;
    wpms_pkg::found_t   emit_data;
    logic               keep;
    logic               clear;

    // Correct the quotient estimate into the reduced query index
    always_comb
    begin
        back_prod = {{MQ_W{1'b0}}, head_entry.query_quot} * {16'd0, MQ};
        rem_est   = head_entry.query_raw - back_prod[15:0];
        rem_ext   = REM_W'(rem_est);
        if (rem_ext >= MQ_EXT)
        begin
            rem_ext = rem_ext - MQ_EXT;
        end
        query = rem_ext[15:0];
    end

    always_comb
    begin
        cand.found_query     = query;
        cand.found_index_pos = head_entry.index_pos;
        cand.found_time      = head_entry.time_pos;
        cand.found_intensity = head_entry.intensity;
    end

    // Take an entry whenever the output register can load
    assign pop = head_valid && (!found_valid_reg || found.ready);

    // Decide emit and keep for the head entry
    always_comb
    begin
        emit_now  = 1'b0;
        emit_data = best_reg;
        keep      = 1'b0;
        clear     = 1'b0;
        if (head_entry.flush)
        begin
            emit_now = have_best_reg;
            clear    = 1'b1;
        end
        else if (search_mode == wpms_pkg::MODE_ALL)
        begin
            emit_now  = 1'b1;
            emit_data = cand;
        end
        else if (!have_best_reg)
        begin
            keep = 1'b1;
        end
        else if (query != best_reg.found_query)
        begin
            emit_now = 1'b1;
            keep     = 1'b1;
        end
        else
        begin
            unique case (search_mode)
                wpms_pkg::MODE_MIN_ERROR:     keep = best_error_reg > head_entry.error;
                wpms_pkg::MODE_MAX_INTENSITY:
                    keep = best_reg.found_intensity < head_entry.intensity;
                default:                      keep = 1'b0;
            endcase
        end
    end

    // Update held best and output register
    always_comb
    begin
        have_best_next   = have_best_reg;
        best_next        = best_reg;
        best_error_next  = best_error_reg;
        found_valid_next = found_valid_reg;
        found_data_next  = found_data_reg;
        if (found_valid_reg && found.ready)
        begin
            found_valid_next = 1'b0;
        end
        if (pop)
        begin
            if (clear)
            begin
                have_best_next = 1'b0;
            end
            if (keep)
            begin
                have_best_next  = 1'b1;
                best_next       = cand;
                best_error_next = head_entry.error;
            end
            if (emit_now)
            begin
                found_valid_next = 1'b1;
                found_data_next  = emit_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg   <= 1'b0;
            found_valid_reg <= 1'b0;
        end
        else
        begin
            have_best_reg   <= have_best_next;
            found_valid_reg <= found_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg       <= best_next;
        best_error_reg <= best_error_next;
        found_data_reg <= found_data_next;
    end

    assign found.valid = found_valid_reg;
    assign found.data  = found_data_reg;

endmodule

`default_nettype wire

// ----- sv/window_peak_match_select.sv -----
// ----------------------------------------------------------------------------
// window_peak_match_select: windowed peak matching with per-query selection
// Matches candidate peaks against library queries and reports every match or
// the best match of each run of equal query index.
// ----------------------------------------------------------------------------
// Usage:
//   item  : valid/ready sink, one candidate peak with its query per item, or a
//           flush item that reports the pending best match.
//   found : valid/ready source, one reported peak per item.
//   cfg_we/cfg_index/cfg_data: write search_mode (index 0) and use_time
//           (index 1) while the block is idle.
// Throughput is one item per cycle while found does not stall: the front
// tests an item in its accept cycle, a two-entry queue passes it on, and the
// back updates the single held best match and the output register together.
// An accepted item's result passes through the queue and the output
// register; a kept match appears when the next query's match or a flush
// reaches the back.
// Reset clears the registers to mode "all" on the index position, empties
// the queue and drops any held best match.
// When found stalls, the output register holds, the queue fills, and item
// ready drops once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module window_peak_match_select #(
    parameter int MAX_QUERIES = 65536
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [wpms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [wpms_pkg::CFG_DATA_W-1:0]  cfg_data,
    wpms_item_if.sink                             item,
    wpms_found_if.source                          found
);

    logic [1:0]       search_mode_reg, search_mode_next;
    logic             use_time_reg, use_time_next;
    logic             push;
    wpms_pkg::entry_t push_entry;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    wpms_pkg::entry_t head_entry;

    // Decode configuration writes
    always_comb
    begin
        search_mode_next = search_mode_reg;
        use_time_next    = use_time_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                wpms_pkg::CFG_SEARCH_MODE: search_mode_next = cfg_data[1:0];
                wpms_pkg::CFG_USE_TIME:    use_time_next    = cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg <= wpms_pkg::MODE_ALL;
            use_time_reg    <= 1'b0;
        end
        else
        begin
            search_mode_reg <= search_mode_next;
            use_time_reg    <= use_time_next;
        end
    end

    wpms_front #(
        .MAX_QUERIES (MAX_QUERIES)
    ) u_front (
        .item       (item),
        .use_time   (use_time_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    wpms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    wpms_back #(
        .MAX_QUERIES (MAX_QUERIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .search_mode (search_mode_reg),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .found       (found)
    );

endmodule

`default_nettype wire
